// ===== hw/rtl/ttb_pkg.sv =====
// shared constants for the triangle tangent/binormal block
`default_nettype none
package ttb_pkg;
	// output component width
	localparam int OUT_W = 16;
	// magnitude bits kept before squaring
	localparam int MAG_BITS = 30;
endpackage
`default_nettype wire

// ===== hw/rtl/ttb_vertex_if.sv =====
// vertex channel: valid/ready plus position and texture coordinate
`default_nettype none
interface ttb_vertex_if #(parameter int CoordWidth = 32);
	logic valid;
	logic ready;
	logic signed [CoordWidth-1:0] pos_x;
	logic signed [CoordWidth-1:0] pos_y;
	logic signed [CoordWidth-1:0] pos_z;
	logic signed [CoordWidth-1:0] tex_u;
	logic signed [CoordWidth-1:0] tex_v;
	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ttb_result_if.sv =====
// result channel: valid/ready plus unit tangent, binormal and degenerate flag
`default_nettype none
interface ttb_result_if;
	logic valid;
	logic ready;
	logic signed [ttb_pkg::OUT_W-1:0] tangent_x;
	logic signed [ttb_pkg::OUT_W-1:0] tangent_y;
	logic signed [ttb_pkg::OUT_W-1:0] tangent_z;
	logic signed [ttb_pkg::OUT_W-1:0] binormal_x;
	logic signed [ttb_pkg::OUT_W-1:0] binormal_y;
	logic signed [ttb_pkg::OUT_W-1:0] binormal_z;
	logic degenerate;
	modport source (output valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
		binormal_z, degenerate, input ready);
	modport sink (input valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
		binormal_z, degenerate, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ttb_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module ttb_div #(
	parameter int NumWidth = 45,
	parameter int DenWidth = 31
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NumWidth-1:0] num,
	input  wire logic [DenWidth-1:0] den,
	output logic                     done,
	output logic [NumWidth-1:0]      quo
);
	localparam int CntW = $clog2(NumWidth + 1);

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [NumWidth-1:0] num_q;
	logic [NumWidth-1:0] quo_q;
	logic [DenWidth-1:0] den_q;
	logic [DenWidth-1:0] rem_q;
	logic [DenWidth:0]   trial;
	logic                ge;

	// shift in the next numerator bit and try the subtract
	assign trial = {rem_q, num_q[NumWidth-1]};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(1));
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumWidth);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DenWidth'(trial - {1'b0, den_q}) : DenWidth'(trial);
			num_q <= num_q << 1;
			quo_q <= {quo_q[NumWidth-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ===== hw/rtl/triangle_tangent_binormal.sv =====
// top level: per-triangle tangent and binormal unit vectors
// Vertices are taken one per transfer and grouped in threes. The first two of a triangle
// are stored; the third starts a sequencer around one shared signed multiplier that
// forms the determinant and both vectors, then for each vector shifts the magnitudes
// down to 30 bits (one bit per cycle), sums three squares, takes an integer square
// root and divides each component (3 divides per vector, plus handoff). Input is not
// ready while a triangle is in flight; stored vertices are.
`default_nettype none
module triangle_tangent_binormal #(
	parameter int COORD_WIDTH       = 32,
	parameter int OUT_FRACTION_BITS = 14
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ttb_vertex_if.sink     vtx,
	ttb_result_if.source   res
);
	localparam int CW  = COORD_WIDTH;
	localparam int F   = OUT_FRACTION_BITS;
	localparam int OW  = ttb_pkg::OUT_W;
	localparam int NB  = ttb_pkg::MAG_BITS;
	localparam int DW  = CW + 1;
	localparam int VW  = 2 * DW + 1;
	localparam int MW  = (DW > NB + 1) ? DW : NB + 1;
	localparam int RW  = NB + 1;
	localparam int SW  = 2 * RW;
	localparam int NW  = NB + F + 1;
	localparam int RCW = $clog2(RW + 1);
	localparam logic [NW-1:0] ONE_Q = NW'(1) << F;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_CHK, S_LOAD, S_SHIFT, S_SQ, S_SQRT, S_DIV, S_OUT
	} state_t;

	state_t         state_q;
	logic [1:0]     phase_q;
	logic [3:0]     step_q;
	logic [1:0]     k_q;
	logic           vsel_q;
	logic           div_run_q;
	logic [RCW-1:0] rcnt_q;
	logic           res_valid_q;

	logic signed [CW-1:0] hp_q [6];
	logic signed [CW-1:0] ht_q [4];
	logic signed [DW-1:0] e1_q [3];
	logic signed [DW-1:0] e2_q [3];
	logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [VW-1:0] acc_q;
	logic signed [VW-1:0] vec_q [7];
	logic [VW-1:0]        mag_q [3];
	logic                 neg_q [3];
	logic [SW-1:0]        sum_q;
	logic [RW+1:0]        rem_q;
	logic [RW-1:0]        root_q;
	logic [OW-1:0]        out_q [6];
	logic                 degen_q;

	logic                  accept;
	logic signed [MW-1:0]  op_a, op_b;
	logic signed [2*MW-1:0] mp;
	logic [VW-1:0]         mag_or;
	logic [RW+3:0]         sq_next, sq_trial;
	logic                  sq_ge;
	logic [RW-1:0]         root_nz;
	logic                  div_start, div_done;
	logic [NW-1:0]         div_num, div_quo, q_clamp, q_signed;
	logic                  det_neg, t_zero, b_zero;
	logic signed [VW-1:0]  vsrc [3];

	assign accept = vtx.valid && vtx.ready;
	assign vtx.ready = (state_q == S_IDLE);

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_MUL: begin
				case (step_q)
					4'd0:  begin op_a = MW'(du1_q); op_b = MW'(dv2_q);   end
					4'd1:  begin op_a = MW'(du2_q); op_b = MW'(dv1_q);   end
					4'd2:  begin op_a = MW'(dv2_q); op_b = MW'(e1_q[0]); end
					4'd3:  begin op_a = MW'(dv1_q); op_b = MW'(e2_q[0]); end
					4'd4:  begin op_a = MW'(dv2_q); op_b = MW'(e1_q[1]); end
					4'd5:  begin op_a = MW'(dv1_q); op_b = MW'(e2_q[1]); end
					4'd6:  begin op_a = MW'(dv2_q); op_b = MW'(e1_q[2]); end
					4'd7:  begin op_a = MW'(dv1_q); op_b = MW'(e2_q[2]); end
					4'd8:  begin op_a = MW'(du1_q); op_b = MW'(e2_q[0]); end
					4'd9:  begin op_a = MW'(du2_q); op_b = MW'(e1_q[0]); end
					4'd10: begin op_a = MW'(du1_q); op_b = MW'(e2_q[1]); end
					4'd11: begin op_a = MW'(du2_q); op_b = MW'(e1_q[1]); end
					4'd12: begin op_a = MW'(du1_q); op_b = MW'(e2_q[2]); end
					4'd13: begin op_a = MW'(du2_q); op_b = MW'(e1_q[2]); end
					default: begin op_a = '0; op_b = '0; end
				endcase
			end
			S_SQ: begin
				op_a = MW'($signed({1'b0, mag_q[k_q][NB-1:0]}));
				op_b = op_a;
			end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end
	assign mp = op_a * op_b;

	// flags and helpers
	assign det_neg = vec_q[0][VW-1];
	assign t_zero  = (vec_q[1] == '0) && (vec_q[2] == '0) && (vec_q[3] == '0);
	assign b_zero  = (vec_q[4] == '0) && (vec_q[5] == '0) && (vec_q[6] == '0);
	assign mag_or  = mag_q[0] | mag_q[1] | mag_q[2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vsrc[i] = vsel_q ? vec_q[4 + i] : vec_q[1 + i];
		end
	end

	// square root step: two radicand bits per cycle
	assign sq_next  = {rem_q, sum_q[SW-1:SW-2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = sq_next >= sq_trial;
	assign root_nz  = (root_q == '0) ? RW'(1) : root_q;

	// divide step setup and result
	assign div_start = (state_q == S_DIV) && !div_run_q;
	assign div_num   = (NW'(mag_q[k_q][NB-1:0]) << F) + NW'(root_nz >> 1);
	assign q_clamp   = (div_quo > ONE_Q) ? ONE_Q : div_quo;
	assign q_signed  = neg_q[k_q] ? (NW'(0) - q_clamp) : q_clamp;

	ttb_div #(
		.NumWidth(NW),
		.DenWidth(RW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (root_nz),
		.done  (div_done),
		.quo   (div_quo)
	);

	// sequencer state and result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			step_q      <= '0;
			k_q         <= '0;
			vsel_q      <= 1'b0;
			div_run_q   <= 1'b0;
			rcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// result valid: set when the basis is loaded, cleared on its transfer
			if ((state_q == S_OUT) && (!res_valid_q || res.ready)) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (phase_q == 2'd2) begin
							phase_q <= '0;
							step_q  <= '0;
							state_q <= S_MUL;
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				S_MUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd13) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					vsel_q <= 1'b0;
					state_q <= ((vec_q[0] == '0) || t_zero || b_zero) ? S_OUT : S_LOAD;
				end
				S_LOAD: state_q <= S_SHIFT;
				S_SHIFT: begin
					if ((mag_or >> NB) == '0) begin
						k_q     <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (k_q == 2'd2) begin
						k_q     <= '0;
						rcnt_q  <= '0;
						state_q <= S_SQRT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_SQRT: begin
					rcnt_q <= rcnt_q + RCW'(1);
					if (rcnt_q == RCW'(RW - 1)) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_start) begin
						div_run_q <= 1'b1;
					end else if (div_done) begin
						div_run_q <= 1'b0;
						if (k_q == 2'd2) begin
							k_q <= '0;
							if (!vsel_q) begin
								vsel_q  <= 1'b1;
								state_q <= S_LOAD;
							end else begin
								state_q <= S_OUT;
							end
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				S_OUT: begin
					if (!res_valid_q || res.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (phase_q == 2'd2) begin
						// edges and uv deltas of the finished triangle
						e1_q[0] <= DW'(hp_q[3]) - DW'(hp_q[0]);
						e1_q[1] <= DW'(hp_q[4]) - DW'(hp_q[1]);
						e1_q[2] <= DW'(hp_q[5]) - DW'(hp_q[2]);
						e2_q[0] <= DW'(vtx.pos_x) - DW'(hp_q[0]);
						e2_q[1] <= DW'(vtx.pos_y) - DW'(hp_q[1]);
						e2_q[2] <= DW'(vtx.pos_z) - DW'(hp_q[2]);
						du1_q   <= DW'(ht_q[2]) - DW'(ht_q[0]);
						dv1_q   <= DW'(ht_q[3]) - DW'(ht_q[1]);
						du2_q   <= DW'(vtx.tex_u) - DW'(ht_q[0]);
						dv2_q   <= DW'(vtx.tex_v) - DW'(ht_q[1]);
					end else if (phase_q[0]) begin
						hp_q[3] <= vtx.pos_x;
						hp_q[4] <= vtx.pos_y;
						hp_q[5] <= vtx.pos_z;
						ht_q[2] <= vtx.tex_u;
						ht_q[3] <= vtx.tex_v;
					end else begin
						hp_q[0] <= vtx.pos_x;
						hp_q[1] <= vtx.pos_y;
						hp_q[2] <= vtx.pos_z;
						ht_q[0] <= vtx.tex_u;
						ht_q[1] <= vtx.tex_v;
					end
				end
			end
			S_MUL: begin
				// even step holds the first product, odd step subtracts the second
				if (!step_q[0]) begin
					acc_q <= VW'(mp);
				end else begin
					vec_q[step_q[3:1]] <= acc_q - VW'(mp);
				end
			end
			S_CHK: begin
				degen_q <= (vec_q[0] == '0) || t_zero || b_zero;
				for (int i = 0; i < 6; i++) begin
					out_q[i] <= '0;
				end
			end
			S_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= vsrc[i][VW-1] ? VW'(-vsrc[i]) : VW'(vsrc[i]);
					neg_q[i] <= vsrc[i][VW-1] ^ det_neg;
				end
				sum_q <= '0;
			end
			S_SHIFT: begin
				if ((mag_or >> NB) != '0) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end
			end
			S_SQ: begin
				sum_q  <= sum_q + SW'(mp);
				rem_q  <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				rem_q  <= sq_ge ? (RW + 2)'(sq_next - sq_trial) : (RW + 2)'(sq_next);
				root_q <= {root_q[RW-2:0], sq_ge};
				sum_q  <= sum_q << 2;
			end
			S_DIV: begin
				if (div_done) begin
					out_q[(vsel_q ? 3'd3 : 3'd0) + {1'b0, k_q}] <= OW'(q_signed);
				end
			end
			S_OUT: begin
				if (!res_valid_q || res.ready) begin
					res.tangent_x  <= out_q[0];
					res.tangent_y  <= out_q[1];
					res.tangent_z  <= out_q[2];
					res.binormal_x <= out_q[3];
					res.binormal_y <= out_q[4];
					res.binormal_z <= out_q[5];
					res.degenerate <= degen_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid = res_valid_q;
endmodule
`default_nettype wire

// ===== dv/triangle_tangent_binormal_tb.sv =====
// testbench for the triangle tangent/binormal block: directed table plus random triangles
`timescale 1ns / 1ps
module triangle_tangent_binormal_tb;
	localparam int CW = 32;
	localparam int FB = 14;
	localparam int WATCHDOG_CYCLES = 20000;
	localparam int RANDOM_ITEMS = 800;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [ttb_pkg::OUT_W-1:0] comp_t;

	typedef struct packed {
		coord_t px, py, pz, u, v;
	} vertex_t;

	typedef struct packed {
		comp_t tx, ty, tz, bx, by, bz;
		logic degen;
	} basis_t;

	// directed row: vertex plus optional typed-in result on the closing vertex
	typedef struct packed {
		vertex_t vtx;
		logic has_fixed;
		basis_t fixed;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ttb_vertex_if #(.CoordWidth(CW)) vtx_ch ();
	ttb_result_if res_ch ();

	triangle_tangent_binormal #(
		.COORD_WIDTH(CW),
		.OUT_FRACTION_BITS(FB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.vtx(vtx_ch.sink),
		.res(res_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [1:0] corner_count = '0;
	logic signed [CW-1:0] held_pos [6];
	logic signed [CW-1:0] held_tex [4];

	basis_t expected_bases [$];
	basis_t fixed_bases [$];
	row_t rows [$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit quiet_tail = 1'b0;
	bit hold_off = 1'b0;

	// bit length of a magnitude
	function automatic int bit_len(logic [127:0] m);
		int n;
		n = 0;
		for (int i = 0; i < 128; i++)
			if (m[i]) n = i + 1;
		return n;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] s);
		logic [63:0] r;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			logic [63:0] c;
			c = r | (64'd1 << i);
			if (c * c <= s) r = c;
		end
		return r;
	endfunction

	// scale one exact vector to Q1.FB
	function automatic void unit_vector(input logic signed [127:0] comp [3],
		output comp_t q [3]);
		logic [127:0] mag [3];
		logic [63:0] m [3];
		logic [63:0] sum, r, d;
		int len, sh;
		len = 0;
		sum = '0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = comp[k] < 0 ? -comp[k] : comp[k];
			if (bit_len(mag[k]) > len) len = bit_len(mag[k]);
		end
		sh = len > ttb_pkg::MAG_BITS ? len - ttb_pkg::MAG_BITS : 0;
		for (int k = 0; k < 3; k++) begin
			m[k] = 64'(mag[k] >> sh);
			sum += m[k] * m[k];
		end
		r = root_floor(sum);
		if (r == 0) r = 1;
		for (int k = 0; k < 3; k++) begin
			d = ((m[k] << FB) + (r >> 1)) / r;
			if (d > (64'd1 << FB)) d = 64'd1 << FB;
			q[k] = comp[k] < 0 ? comp_t'(-d) : comp_t'(d);
		end
	endfunction

	// advance the predictor by one vertex; returns 1 when a triangle closes
	function automatic bit predict_basis(vertex_t vx, output basis_t b);
		logic signed [127:0] e1 [3], e2 [3], tv [3], bv [3];
		logic signed [127:0] du1, dv1, du2, dv2, det;
		coord_t p [3];
		comp_t qt [3], qb [3];
		p[0] = vx.px; p[1] = vx.py; p[2] = vx.pz;
		b = '0;
		if (corner_count < 2) begin
			for (int k = 0; k < 3; k++) held_pos[corner_count * 3 + k] = p[k];
			held_tex[corner_count * 2] = vx.u;
			held_tex[corner_count * 2 + 1] = vx.v;
			corner_count++;
			return 1'b0;
		end
		corner_count = '0;
		for (int k = 0; k < 3; k++) begin
			e1[k] = 128'(held_pos[3 + k]) - 128'(held_pos[k]);
			e2[k] = 128'(p[k]) - 128'(held_pos[k]);
		end
		du1 = 128'(held_tex[2]) - 128'(held_tex[0]);
		dv1 = 128'(held_tex[3]) - 128'(held_tex[1]);
		du2 = 128'(vx.u) - 128'(held_tex[0]);
		dv2 = 128'(vx.v) - 128'(held_tex[1]);
		det = du1 * dv2 - du2 * dv1;
		for (int k = 0; k < 3; k++) begin
			tv[k] = dv2 * e1[k] - dv1 * e2[k];
			bv[k] = du1 * e2[k] - du2 * e1[k];
			if (det < 0) begin
				tv[k] = -tv[k];
				bv[k] = -bv[k];
			end
		end
		if (det == 0 || (tv[0] == 0 && tv[1] == 0 && tv[2] == 0) ||
			(bv[0] == 0 && bv[1] == 0 && bv[2] == 0)) begin
			b.degen = 1'b1;
			return 1'b1;
		end
		unit_vector(tv, qt);
		unit_vector(bv, qb);
		b.tx = qt[0]; b.ty = qt[1]; b.tz = qt[2];
		b.bx = qb[0]; b.by = qb[1]; b.bz = qb[2];
		return 1'b1;
	endfunction

	function automatic vertex_t mk_vtx(int px, int py, int pz, int u, int v);
		vertex_t x;
		x.px = px; x.py = py; x.pz = pz; x.u = u; x.v = v;
		return x;
	endfunction

	function automatic basis_t mk_basis(int tx, int ty, int tz, int bx, int by, int bz,
		bit dg);
		basis_t b;
		b.tx = comp_t'(tx); b.ty = comp_t'(ty); b.tz = comp_t'(tz);
		b.bx = comp_t'(bx); b.by = comp_t'(by); b.bz = comp_t'(bz);
		b.degen = dg;
		return b;
	endfunction

	function automatic row_t mk_row(vertex_t v, bit has, basis_t b);
		row_t r;
		r.vtx = v; r.has_fixed = has; r.fixed = b;
		return r;
	endfunction

	// append one row to the directed table
	function automatic void add_row(vertex_t v, bit has, basis_t b);
		rows.insert(rows.size(), mk_row(v, has, b));
	endfunction

	// random coordinate: mostly modest, sometimes full range or extreme
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return coord_t'($urandom);
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return coord_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
		endcase
	endfunction

	function automatic vertex_t rand_vtx();
		return mk_vtx(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endfunction

	task automatic idle_burst();
		repeat ($urandom_range(1, 11)) @(posedge clk);
	endtask

	// offer one vertex, wait for its transfer and update the predictor
	task automatic send_vertex(vertex_t vx, bit has_fixed, basis_t fixed);
		basis_t b;
		vtx_ch.valid <= 1'b1;
		vtx_ch.pos_x <= vx.px;
		vtx_ch.pos_y <= vx.py;
		vtx_ch.pos_z <= vx.pz;
		vtx_ch.tex_u <= vx.u;
		vtx_ch.tex_v <= vx.v;
		do @(posedge clk); while (!vtx_ch.ready);
		if (predict_basis(vx, b)) begin
			expected_bases.insert(expected_bases.size(), b);
			fixed_bases.insert(fixed_bases.size(), has_fixed ? fixed : b);
		end
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			vtx_ch.valid <= 1'b0;
			idle_burst();
		end
	endtask

	function automatic void check_field(string name, logic [15:0] exp, logic [15:0] act);
		if (exp !== act) begin
			$error("%s: expected %0d actual %0d", name, $signed(exp), $signed(act));
			fail_count++;
		end
	endfunction

	// result monitor
	always @(posedge clk) begin
		basis_t e, g;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_bases.size() == 0) begin
				$error("result transfer with no triangle outstanding");
				fail_count++;
			end else begin
				e = expected_bases.pop_front();
				g = fixed_bases.pop_front();
				if (g !== e) begin
					$error("typed-in result disagrees with predictor");
					fail_count++;
				end
				check_field("tangent_x", e.tx, res_ch.tangent_x);
				check_field("tangent_y", e.ty, res_ch.tangent_y);
				check_field("tangent_z", e.tz, res_ch.tangent_z);
				check_field("binormal_x", e.bx, res_ch.binormal_x);
				check_field("binormal_y", e.by, res_ch.binormal_y);
				check_field("binormal_z", e.bz, res_ch.binormal_z);
				check_field("degenerate", 16'(e.degen), 16'(res_ch.degenerate));
			end
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				res_ch.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				idle_burst();
			end
			res_ch.ready <= 1'b1;
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		basis_t none;
		none = '0;
		vtx_ch.valid = 1'b0;
		vtx_ch.pos_x = '0;
		vtx_ch.pos_y = '0;
		vtx_ch.pos_z = '0;
		vtx_ch.tex_u = '0;
		vtx_ch.tex_v = '0;

		// axis-aligned triangle: tangent +x, binormal +y
		add_row(mk_vtx(0, 0, 0, 0, 0), 0, none);
		add_row(mk_vtx(65536, 0, 0, 65536, 0), 0, none);
		add_row(mk_vtx(0, 65536, 0, 0, 65536), 1, mk_basis(16384, 0, 0, 0, 16384, 0, 0));
		// mirrored u: negative determinant, tangent along -x
		add_row(mk_vtx(0, 0, 0, 0, 0), 0, none);
		add_row(mk_vtx(65536, 0, 0, -65536, 0), 0, none);
		add_row(mk_vtx(0, 65536, 0, 0, 65536), 1, mk_basis(-16384, 0, 0, 0, 16384, 0, 0));
		// zero determinant: identical uv
		add_row(mk_vtx(1, 2, 3, 7, 7), 0, none);
		add_row(mk_vtx(5, 9, -3, 7, 7), 0, none);
		add_row(mk_vtx(-4, 0, 8, 7, 7), 1, mk_basis(0, 0, 0, 0, 0, 0, 1));
		// zero vectors: collapsed positions, good uv
		add_row(mk_vtx(3, 3, 3, 0, 0), 0, none);
		add_row(mk_vtx(3, 3, 3, 65536, 0), 0, none);
		add_row(mk_vtx(3, 3, 3, 0, 65536), 1, mk_basis(0, 0, 0, 0, 0, 0, 1));
		// extreme coordinates, wide products and shift-down
		add_row(mk_vtx(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000), 0, none);
		add_row(mk_vtx(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000), 0, none);
		add_row(mk_vtx(32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h7fffffff), 0, none);
		add_row(mk_vtx(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff), 0, none);
		add_row(mk_vtx(-1, -1, -1, -1, 0), 0, none);
		add_row(mk_vtx(32'h80000000, 0, 32'h7fffffff, 0, 32'h80000000), 0, none);
		// tiny edges: root of small sums
		add_row(mk_vtx(0, 0, 0, 0, 0), 0, none);
		add_row(mk_vtx(1, 1, 0, 1, 0), 0, none);
		add_row(mk_vtx(0, 1, 1, 0, 1), 0, none);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_vertex(rows[i].vtx, rows[i].has_fixed, rows[i].fixed);

		// long receiver hold-off while vertices keep coming
		hold_off = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i += 3) begin
			vertex_t a;
			if (i > RANDOM_ITEMS * 7 / 8) quiet_tail = 1'b1;
			a = rand_vtx();
			send_vertex(a, 0, none);
			if (($urandom_range(0, 9)) == 0) begin
				// degenerate: repeated vertex
				send_vertex(a, 0, none);
			end else begin
				send_vertex(rand_vtx(), 0, none);
			end
			send_vertex(rand_vtx(), 0, none);
		end
		vtx_ch.valid <= 1'b0;

		while (expected_bases.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== triangle_tangent_binormal.f =====
hw/rtl/ttb_pkg.sv
hw/rtl/ttb_vertex_if.sv
hw/rtl/ttb_result_if.sv
hw/rtl/ttb_div.sv
hw/rtl/triangle_tangent_binormal.sv
dv/triangle_tangent_binormal_tb.sv
